FILE: hw/rtl/recycling_index_allocator_assert.svh
// assertion macros used by the allocator checker
`ifndef RECYCLING_INDEX_ALLOCATOR_ASSERT_SVH
`define RECYCLING_INDEX_ALLOCATOR_ASSERT_SVH

// property checked on every clock edge outside reset
`define RIA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property that also has to hold through reset
`define RIA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/ria_pkg.sv
package ria_pkg;

   localparam int DEFAULT_TAG_COUNT = 256;
   localparam int TAG_W = 8;

   typedef enum logic {
      OP_ALLOC  = 1'b0,
      OP_RETURN = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_GRANTED   = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_RET_OK    = 2'd2,
      STATUS_RET_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      op_type           op;
      logic [TAG_W-1:0] tag_in;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag_out;
      status_type       status;
   } rsp_type;

   // outcome of one word, carried from the controller into the pipeline
   typedef struct packed {
      status_type       status;
      logic             from_queue;
      logic [TAG_W-1:0] fresh_tag;
   } decision_type;

endpackage

FILE: hw/rtl/ria_ram.sv
module ria_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ria_ctrl.sv
module ria_ctrl import ria_pkg::*; #(
   parameter int TAG_COUNT = DEFAULT_TAG_COUNT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  req_type                      req,
   output decision_type                 decision,
   output logic                         ram_wr_en,
   output logic [$clog2(TAG_COUNT)-1:0] ram_wr_addr,
   output logic [TAG_W-1:0]             ram_wr_data,
   output logic                         ram_rd_en,
   output logic [$clog2(TAG_COUNT)-1:0] ram_rd_addr
);

   localparam int AW = $clog2(TAG_COUNT);
   localparam int CW = $clog2(TAG_COUNT + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] fresh_ff, fresh_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;

   logic queue_empty;
   logic queue_full;
   logic fresh_left;
   logic pop;
   logic push;
   logic take_fresh;

   assign queue_empty = (count_ff == '0);
   assign queue_full  = (count_ff == CW'(TAG_COUNT));
   assign fresh_left  = (fresh_ff != CW'(TAG_COUNT));

   always_comb begin
      pop        = 1'b0;
      push       = 1'b0;
      take_fresh = 1'b0;
      decision   = '{status: STATUS_GRANTED, from_queue: 1'b0, fresh_tag: '0};
      unique case (req.op)
         OP_ALLOC: begin
            // recycled tags go out before fresh ones
            if (!queue_empty) begin
               pop                 = 1'b1;
               decision.from_queue = 1'b1;
            end else if (fresh_left) begin
               take_fresh         = 1'b1;
               decision.fresh_tag = TAG_W'(fresh_ff);
            end else begin
               decision.status = STATUS_EXHAUSTED;
            end
         end
         OP_RETURN: begin
            if (queue_full) begin
               decision.status = STATUS_RET_FULL;
            end else begin
               push            = 1'b1;
               decision.status = STATUS_RET_OK;
            end
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      fresh_in = fresh_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (accept) begin
         if (pop) begin
            count_in = count_ff - 1'b1;
            head_in  = (head_ff == AW'(TAG_COUNT - 1)) ? '0 : head_ff + 1'b1;
         end
         if (push) begin
            count_in = count_ff + 1'b1;
            tail_in  = (tail_ff == AW'(TAG_COUNT - 1)) ? '0 : tail_ff + 1'b1;
         end
         if (take_fresh) begin
            fresh_in = fresh_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fresh_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         count_ff <= count_in;
         fresh_ff <= fresh_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   assign ram_wr_en   = accept && push;
   assign ram_wr_addr = tail_ff;
   assign ram_wr_data = req.tag_in;
   assign ram_rd_en   = accept && pop;
   assign ram_rd_addr = head_ff;

endmodule

FILE: hw/rtl/recycling_index_allocator.sv
// pipeline: an accepted request word's decision is registered in s1, then its response word in the output register
// throughput: one word per cycle while rsp_ready stays high; the recycle queue ram takes one
// write and one registered read per cycle
// reset: synchronous; clears the fresh counter, queue pointers and count and
// empties the pipeline; queue ram contents are left as they are (no clear pass)
module recycling_index_allocator import ria_pkg::*; #(
   parameter int TAG_COUNT = DEFAULT_TAG_COUNT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(TAG_COUNT);

   logic         accept;
   decision_type decision;
   logic         ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [TAG_W-1:0] ram_wr_data;
   logic         ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [TAG_W-1:0] ram_rd_data;

   logic         s1_valid_ff, s1_valid_in;
   decision_type s1_dec_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_type      out_data_ff, out_data_in;
   logic         s1_move;

   assign s1_move   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   ria_ctrl #(
      .TAG_COUNT(TAG_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .decision   (decision),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr)
   );

   ria_ram #(
      .WIDTH(TAG_W),
      .DEPTH(TAG_COUNT)
   ) u_queue_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      // ram read data is held until the next read, which needs s1 to move
      out_data_in.status  = s1_dec_ff.status;
      out_data_in.tag_out = s1_dec_ff.from_queue ? ram_rd_data : s1_dec_ff.fresh_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         s1_dec_ff <= decision;
      end
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: hw/rtl/ria_checker.sv
`include "recycling_index_allocator_assert.svh"

module ria_checker import ria_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic non_grant;
   logic rsp_stall;

   assign non_grant = rsp_valid && (rsp_data.status != STATUS_GRANTED);
   assign rsp_stall = rsp_valid && !rsp_ready;

   // only grants carry a tag
   `RIA_ASSERT(a_tag_only_on_grant, non_grant |-> rsp_data.tag_out == '0, "tag without a grant")

   // an empty output stage always leaves room for a request word
   `RIA_ASSERT(a_ready_when_out_empty, !rsp_valid |-> req_ready, "stall with empty output")

   `RIA_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "response valid after reset")

   `RIA_ASSERT(a_rsp_holds, rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled word changed")

endmodule

bind recycling_index_allocator ria_checker u_ria_checker (.*);
